/* design/e2g_pkg.sv */
// Shared types, widths and constants for the ECEF to geodetic pipeline.
// Used by every module of the block but the port checker e2g_chk; depends on nothing.
`default_nettype none

package e2g_pkg;

   // Number of CORDIC micro-rotations in each vectoring and rotation unit (16 to 48).
   localparam int CORDIC_STAGES = 32;

   localparam int AW       = 32;   // angle width, turns * 2^32
   localparam int VW       = 52;   // length datapath, cm * 2^16
   localparam int RW       = 34;   // sine/cosine datapath, Q30
   localparam int FRAC     = 30;   // fraction bits of the Q30 products
   localparam int LEN_BITS = 16;   // fraction bits of a length
   localparam int MUL_HW   = VW - FRAC + RW;
   localparam int MUL_LW   = FRAC + RW;

   // Integer square root of a 62-bit word, one result bit per stage.
   localparam int SQ_STEPS = 31;
   localparam int SQ_NW    = 62;
   localparam int SQ_RW    = 31;
   localparam int SQ_TOP   = 2 * (SQ_STEPS - 1);

   localparam int AM_W     = 47;   // (a * root) >> 14

   localparam logic [AW-1:0]        HALF_TURN = 32'h8000_0000;
   localparam logic signed [RW-1:0] Q30_ONE   = 34'sd1073741824;
   localparam logic signed [RW-1:0] TWO_Q30   = 34'sd2147483648;
   localparam logic signed [RW-1:0] INVK_Q30  = 34'sd652032874;
   localparam logic signed [RW-1:0] BA_Q30    = 34'sd1070141771;
   localparam logic signed [RW-1:0] E2_Q30    = 34'sd7188035;
   localparam logic signed [31:0]   EPB_Q8    = 32'sd1096737575;
   localparam logic signed [31:0]   EAC_Q8    = 32'sd1093060423;
   localparam logic [29:0]          A_CM      = 30'd637813700;
   localparam logic signed [AW-1:0] LAT_MAX   = 32'sd1073741824;
   localparam logic signed [AW-1:0] LAT_MIN   = -32'sd1073741824;
   localparam logic signed [30:0]   H_MAX     = 31'sd1073741823;
   localparam logic signed [30:0]   H_MIN     = -31'sd1073741824;

   localparam logic [AW-1:0] ATAN_TAB [0:29] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
   };

   // Arctangent of 2^-idx in turns * 2^32; the table runs out to zero past 29.
   function automatic logic [AW-1:0] atan_entry(input int idx);
      logic [AW-1:0] r;
      r = '0;
      if (idx < 30) begin
         r = ATAN_TAB[idx[4:0]];
      end
      return r;
   endfunction

   // Everything an item carries alongside the arithmetic units.
   typedef struct packed {
      logic                 deg;
      logic                 zpos;
      logic                 zneg;
      logic                 nz0;
      logic [AW-1:0]        lon;
      logic signed [AW-1:0] lat;
      logic signed [VW-1:0] p;
      logic signed [VW-1:0] zs;
      logic signed [VW-1:0] pc;
      logic signed [VW-1:0] zsv;
      logic signed [RW-1:0] c;
      logic signed [RW-1:0] s;
   } side_type;

endpackage

`default_nettype wire

/* design/ecef_to_geodetic.sv */
// ECEF to WGS84 geodetic conversion (Bowring one-step latitude), fully pipelined.
// Throughput is one point per cycle; a stalled output freezes the whole pipeline in place.
// Synchronous active-high reset clears all valid bits; payload registers are not reset.
// Depends on e2g_pkg, e2g_vec, e2g_rot, e2g_mul and e2g_sqrt.
`default_nettype none

module ecef_to_geodetic
   import e2g_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [30:0] req_x_cm,
   input  logic signed [30:0] req_y_cm,
   input  logic signed [30:0] req_z_cm,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_longitude_turns,
   output logic signed [31:0] rsp_latitude_angle,
   output logic signed [30:0] rsp_height_cm,
   output logic               rsp_degenerate
);

   // The pipeline moves as one: every stage advances unless the output beat is
   // held by the consumer. An empty output register never blocks the pipeline.
   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // ---------------------------------------------------------------------
   // Input stage: scale to cm * 2^16 and flag the polar axis.
   // ---------------------------------------------------------------------
   logic                 in_vld_ff;
   logic signed [VW-1:0] xs_ff;
   logic signed [VW-1:0] ys_ff;
   side_type             side0_ff;
   side_type             side0_in;

   always_comb begin
      side0_in      = '0;
      side0_in.zs   = VW'(req_z_cm) <<< LEN_BITS;
      side0_in.deg  = (req_x_cm == '0) && (req_y_cm == '0);
      side0_in.zpos = !req_z_cm[30] && (req_z_cm != '0);
      side0_in.zneg = req_z_cm[30];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (en) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xs_ff    <= VW'(req_x_cm) <<< LEN_BITS;
         ys_ff    <= VW'(req_y_cm) <<< LEN_BITS;
         side0_ff <= side0_in;
      end
   end

   // ---------------------------------------------------------------------
   // Longitude and horizontal distance p.
   // ---------------------------------------------------------------------
   logic                 v1_vld;
   logic [AW-1:0]        v1_ang;
   logic signed [VW-1:0] v1_mag;
   side_type             v1_side;
   side_type             side1;

   e2g_vec u_vec_lon (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .vld_i  (in_vld_ff),
      .x_i    (xs_ff),
      .y_i    (ys_ff),
      .side_i (side0_ff),
      .vld_o  (v1_vld),
      .ang_o  (v1_ang),
      .mag_o  (v1_mag),
      .side_o (v1_side)
   );

   always_comb begin
      side1     = v1_side;
      side1.lon = v1_ang;
   end

   // The CORDIC gain is removed by a multiply with 1/K.
   logic                 m1_vld;
   logic signed [VW-1:0] m1_p;
   side_type             m1_side;
   side_type             side2;

   e2g_mul u_mul_gain (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .vld_i  (v1_vld),
      .a_i    (v1_mag),
      .c_i    (INVK_Q30),
      .side_i (side1),
      .vld_o  (m1_vld),
      .prod_o (m1_p),
      .side_o (m1_side)
   );

   always_comb begin
      side2   = m1_side;
      side2.p = m1_p;
   end

   // ---------------------------------------------------------------------
   // Parametric angle th = atan2(z, (b/a) p) and its sine and cosine.
   // ---------------------------------------------------------------------
   logic                 m2_vld;
   logic signed [VW-1:0] m2_pba;
   side_type             m2_side;

   e2g_mul u_mul_ba (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .vld_i  (m1_vld),
      .a_i    (m1_p),
      .c_i    (BA_Q30),
      .side_i (side2),
      .vld_o  (m2_vld),
      .prod_o (m2_pba),
      .side_o (m2_side)
   );

   logic          v2_vld;
   logic [AW-1:0] v2_th;
   side_type      v2_side;

   e2g_vec u_vec_th (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .vld_i  (m2_vld),
      .x_i    (m2_pba),
      .y_i    (m2_side.zs),
      .side_i (m2_side),
      .vld_o  (v2_vld),
      .ang_o  (v2_th),
      .mag_o  (),
      .side_o (v2_side)
   );

   logic                 r1_vld;
   logic signed [RW-1:0] r1_c;
   logic signed [RW-1:0] r1_s;
   side_type             r1_side;
   side_type             side3;

   e2g_rot u_rot_th (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .vld_i  (v2_vld),
      .ang_i  ($signed(v2_th)),
      .side_i (v2_side),
      .vld_o  (r1_vld),
      .cos_o  (r1_c),
      .sin_o  (r1_s),
      .side_o (r1_side)
   );

   always_comb begin
      side3   = r1_side;
      side3.c = r1_c;
      side3.s = r1_s;
   end

   // ---------------------------------------------------------------------
   // Cubes of sin th and cos th, two multiplies each, side by side.
   // ---------------------------------------------------------------------
   logic                 m3_vld;
   logic signed [VW-1:0] m3_ss;
   logic signed [VW-1:0] m3_cc;
   side_type             m3_side;

   e2g_mul u_mul_ss (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .vld_i  (r1_vld),
      .a_i    (VW'(r1_s)),
      .c_i    (r1_s),
      .side_i (side3),
      .vld_o  (m3_vld),
      .prod_o (m3_ss),
      .side_o (m3_side)
   );

   e2g_mul u_mul_cc (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .vld_i  (r1_vld),
      .a_i    (VW'(r1_c)),
      .c_i    (r1_c),
      .side_i (side3),
      .vld_o  (),
      .prod_o (m3_cc),
      .side_o ()
   );

   logic                 m4_vld;
   logic signed [VW-1:0] m4_s3;
   logic signed [VW-1:0] m4_c3;
   side_type             m4_side;

   e2g_mul u_mul_s3 (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .vld_i  (m3_vld),
      .a_i    (m3_ss),
      .c_i    (m3_side.s),
      .side_i (m3_side),
      .vld_o  (m4_vld),
      .prod_o (m4_s3),
      .side_o (m4_side)
   );

   e2g_mul u_mul_c3 (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .vld_i  (m3_vld),
      .a_i    (m3_cc),
      .c_i    (m3_side.c),
      .side_i (m3_side),
      .vld_o  (),
      .prod_o (m4_c3),
      .side_o ()
   );

   // ---------------------------------------------------------------------
   // Bowring correction terms, then the numerator and denominator of the
   // latitude arctangent. A negative denominator is clipped to zero.
   // ---------------------------------------------------------------------
   logic               p1_vld_ff;
   logic signed [63:0] pn_ff;
   logic signed [63:0] pd_ff;
   side_type           p1_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
      end else if (en) begin
         p1_vld_ff <= m4_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pn_ff      <= $signed(m4_s3[31:0]) * EPB_Q8;
         pd_ff      <= $signed(m4_c3[31:0]) * EAC_Q8;
         p1_side_ff <= m4_side;
      end
   end

   logic signed [VW-1:0] num_w;
   logic signed [VW-1:0] den_w;

   assign num_w = p1_side_ff.zs + VW'(pn_ff >>> 22);
   assign den_w = p1_side_ff.p - VW'(pd_ff >>> 22);

   logic                 p2_vld_ff;
   logic signed [VW-1:0] num_ff;
   logic signed [VW-1:0] den_ff;
   side_type             p2_side_ff;
   side_type             p2_side_in;

   always_comb begin
      p2_side_in     = p1_side_ff;
      p2_side_in.nz0 = (num_w == '0) && (den_w[VW-1] || (den_w == '0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_vld_ff <= 1'b0;
      end else if (en) begin
         p2_vld_ff <= p1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff     <= num_w;
         den_ff     <= den_w[VW-1] ? '0 : den_w;
         p2_side_ff <= p2_side_in;
      end
   end

   // ---------------------------------------------------------------------
   // Latitude, clamped to a quarter turn either way.
   // ---------------------------------------------------------------------
   logic          v3_vld;
   logic [AW-1:0] v3_ang;
   side_type      v3_side;

   e2g_vec u_vec_lat (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .vld_i  (p2_vld_ff),
      .x_i    (den_ff),
      .y_i    (num_ff),
      .side_i (p2_side_ff),
      .vld_o  (v3_vld),
      .ang_o  (v3_ang),
      .mag_o  (),
      .side_o (v3_side)
   );

   logic signed [AW-1:0] lat_w;

   always_comb begin
      priority if (v3_side.nz0) begin
         lat_w = '0;
      end else if ($signed(v3_ang) > LAT_MAX) begin
         lat_w = LAT_MAX;
      end else if ($signed(v3_ang) < LAT_MIN) begin
         lat_w = LAT_MIN;
      end else begin
         lat_w = $signed(v3_ang);
      end
   end

   logic     l_vld_ff;
   side_type l_side_ff;
   side_type l_side_in;

   always_comb begin
      l_side_in     = v3_side;
      l_side_in.lat = lat_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         l_vld_ff <= 1'b0;
      end else if (en) begin
         l_vld_ff <= v3_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         l_side_ff <= l_side_in;
      end
   end

   // ---------------------------------------------------------------------
   // Height: h = p cos(lat) + z sin(lat) - a sqrt(1 - e^2 sin^2(lat)).
   // ---------------------------------------------------------------------
   logic                 r2_vld;
   logic signed [RW-1:0] r2_c;
   logic signed [RW-1:0] r2_s;
   side_type             r2_side;

   e2g_rot u_rot_lat (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .vld_i  (l_vld_ff),
      .ang_i  (l_side_ff.lat),
      .side_i (l_side_ff),
      .vld_o  (r2_vld),
      .cos_o  (r2_c),
      .sin_o  (r2_s),
      .side_o (r2_side)
   );

   logic                 m5_vld;
   logic signed [VW-1:0] m5_ss;
   logic signed [VW-1:0] m6_pc;
   logic signed [VW-1:0] m6_zsv;
   side_type             m5_side;
   side_type             side4;

   e2g_mul u_mul_lat_ss (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .vld_i  (r2_vld),
      .a_i    (VW'(r2_s)),
      .c_i    (r2_s),
      .side_i (r2_side),
      .vld_o  (m5_vld),
      .prod_o (m5_ss),
      .side_o (m5_side)
   );

   e2g_mul u_mul_pc (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .vld_i  (r2_vld),
      .a_i    (r2_side.p),
      .c_i    (r2_c),
      .side_i (r2_side),
      .vld_o  (),
      .prod_o (m6_pc),
      .side_o ()
   );

   e2g_mul u_mul_zs (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .vld_i  (r2_vld),
      .a_i    (r2_side.zs),
      .c_i    (r2_s),
      .side_i (r2_side),
      .vld_o  (),
      .prod_o (m6_zsv),
      .side_o ()
   );

   always_comb begin
      side4     = m5_side;
      side4.pc  = m6_pc;
      side4.zsv = m6_zsv;
   end

   logic                 m7_vld;
   logic signed [VW-1:0] m7_t;
   side_type             m7_side;

   e2g_mul u_mul_e2 (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .vld_i  (m5_vld),
      .a_i    (m5_ss),
      .c_i    (E2_Q30),
      .side_i (side4),
      .vld_o  (m7_vld),
      .prod_o (m7_t),
      .side_o (m7_side)
   );

   logic signed [VW-1:0] w_w;
   logic                 w_vld_ff;
   logic [SQ_RW-1:0]     w_ff;
   side_type             w_side_ff;

   assign w_w = VW'(Q30_ONE) - m7_t;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_vld_ff <= 1'b0;
      end else if (en) begin
         w_vld_ff <= m7_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w_ff      <= w_w[VW-1] ? '0 : w_w[SQ_RW-1:0];
         w_side_ff <= m7_side;
      end
   end

   logic             sq_vld;
   logic [SQ_RW-1:0] sq_root;
   side_type         sq_side;

   e2g_sqrt u_sqrt (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .vld_i  (w_vld_ff),
      .w_i    (w_ff),
      .side_i (w_side_ff),
      .vld_o  (sq_vld),
      .root_o (sq_root),
      .side_o (sq_side)
   );

   // Radius of curvature term a * sqrt(w) and the sum of the two projections.
   logic                 h1_vld_ff;
   logic [AM_W-1:0]      am_ff;
   logic signed [VW:0]   hsum_ff;
   side_type             h1_side_ff;
   logic [60:0]          am_full;

   assign am_full = A_CM * sq_root;

   always_ff @(posedge clock) begin
      if (reset) begin
         h1_vld_ff <= 1'b0;
      end else if (en) begin
         h1_vld_ff <= sq_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         am_ff      <= am_full[60:14];
         hsum_ff    <= (VW+1)'(sq_side.pc) + (VW+1)'(sq_side.zsv);
         h1_side_ff <= sq_side;
      end
   end

   // Round to whole centimetres, saturate, and apply the polar-axis override.
   logic signed [VW+1:0] hs_w;
   logic signed [VW+1:0] hr_w;
   logic signed [30:0]   h_w;

   assign hs_w = (VW+2)'(hsum_ff) - (VW+2)'($signed({1'b0, am_ff}));
   assign hr_w = (hs_w + (VW+2)'(1 << (LEN_BITS - 1))) >>> LEN_BITS;

   always_comb begin
      priority if (hr_w > (VW+2)'(H_MAX)) begin
         h_w = H_MAX;
      end else if (hr_w < (VW+2)'(H_MIN)) begin
         h_w = H_MIN;
      end else begin
         h_w = hr_w[30:0];
      end
   end

   logic                 rsp_valid_ff;
   logic [AW-1:0]        lon_ff;
   logic signed [AW-1:0] lat_ff;
   logic signed [30:0]   h_ff;
   logic                 deg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= h1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         deg_ff <= h1_side_ff.deg;
         if (h1_side_ff.deg) begin
            lon_ff <= '0;
            h_ff   <= '0;
            if (h1_side_ff.zpos) begin
               lat_ff <= LAT_MAX;
            end else if (h1_side_ff.zneg) begin
               lat_ff <= LAT_MIN;
            end else begin
               lat_ff <= '0;
            end
         end else begin
            lon_ff <= h1_side_ff.lon;
            lat_ff <= h1_side_ff.lat;
            h_ff   <= h_w;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_longitude_turns = lon_ff;
   assign rsp_latitude_angle  = lat_ff;
   assign rsp_height_cm       = h_ff;
   assign rsp_degenerate      = deg_ff;

endmodule

`default_nettype wire

/* design/e2g_vec.sv */
// Pipelined CORDIC in vectoring mode: atan2(y, x) in turns and the scaled magnitude.
// Depends on e2g_pkg.
`default_nettype none

module e2g_vec
   import e2g_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 vld_i,
   input  logic signed [VW-1:0] x_i,
   input  logic signed [VW-1:0] y_i,
   input  side_type             side_i,
   output logic                 vld_o,
   output logic [AW-1:0]        ang_o,
   output logic signed [VW-1:0] mag_o,
   output side_type             side_o
);

   logic                 vld_ff  [0:CORDIC_STAGES];
   logic signed [VW-1:0] x_ff    [0:CORDIC_STAGES];
   logic signed [VW-1:0] y_ff    [0:CORDIC_STAGES];
   logic [AW-1:0]        ang_ff  [0:CORDIC_STAGES];
   side_type             side_ff [0:CORDIC_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= vld_i;
      end
   end

   // A vector in the left half plane is turned by half a turn first.
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_i;
         if (x_i[VW-1]) begin
            x_ff[0]   <= -x_i;
            y_ff[0]   <= -y_i;
            ang_ff[0] <= HALF_TURN;
         end else begin
            x_ff[0]   <= x_i;
            y_ff[0]   <= y_i;
            ang_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (en) begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[i+1] <= side_ff[i];
            if (!y_ff[i][VW-1]) begin
               x_ff[i+1]   <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1]   <= y_ff[i] - (x_ff[i] >>> i);
               ang_ff[i+1] <= ang_ff[i] + atan_entry(i);
            end else begin
               x_ff[i+1]   <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1]   <= y_ff[i] + (x_ff[i] >>> i);
               ang_ff[i+1] <= ang_ff[i] - atan_entry(i);
            end
         end
      end
   end

   assign vld_o  = vld_ff[CORDIC_STAGES];
   assign ang_o  = ang_ff[CORDIC_STAGES];
   assign mag_o  = x_ff[CORDIC_STAGES];
   assign side_o = side_ff[CORDIC_STAGES];

endmodule

`default_nettype wire

/* design/e2g_rot.sv */
// Pipelined CORDIC in rotation mode: Q30 cosine and sine of a signed angle in turns.
// Depends on e2g_pkg.
`default_nettype none

module e2g_rot
   import e2g_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 vld_i,
   input  logic signed [AW-1:0] ang_i,
   input  side_type             side_i,
   output logic                 vld_o,
   output logic signed [RW-1:0] cos_o,
   output logic signed [RW-1:0] sin_o,
   output side_type             side_o
);

   logic                 vld_ff  [0:CORDIC_STAGES+1];
   side_type             side_ff [0:CORDIC_STAGES+1];
   logic signed [RW-1:0] x_ff    [0:CORDIC_STAGES];
   logic signed [RW-1:0] y_ff    [0:CORDIC_STAGES];
   logic signed [RW-1:0] a_ff    [0:CORDIC_STAGES];
   logic                 flip_ff [0:CORDIC_STAGES];
   logic signed [RW-1:0] cos_ff;
   logic signed [RW-1:0] sin_ff;
   logic signed [RW-1:0] ang_ext;

   assign ang_ext = RW'(ang_i);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= vld_i;
      end
   end

   // Angles beyond a quarter turn are folded by half a turn and the result negated.
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_i;
         x_ff[0]    <= INVK_Q30;
         y_ff[0]    <= '0;
         if (ang_ext > Q30_ONE) begin
            a_ff[0]    <= ang_ext - TWO_Q30;
            flip_ff[0] <= 1'b1;
         end else if (ang_ext < -Q30_ONE) begin
            a_ff[0]    <= ang_ext + TWO_Q30;
            flip_ff[0] <= 1'b1;
         end else begin
            a_ff[0]    <= ang_ext;
            flip_ff[0] <= 1'b0;
         end
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      localparam logic signed [RW-1:0] STEP = $signed({{(RW-AW){1'b0}}, atan_entry(i)});

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (en) begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[i+1] <= side_ff[i];
            flip_ff[i+1] <= flip_ff[i];
            if (!a_ff[i][RW-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               a_ff[i+1] <= a_ff[i] - STEP;
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               a_ff[i+1] <= a_ff[i] + STEP;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[CORDIC_STAGES+1] <= 1'b0;
      end else if (en) begin
         vld_ff[CORDIC_STAGES+1] <= vld_ff[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[CORDIC_STAGES+1] <= side_ff[CORDIC_STAGES];
         cos_ff <= flip_ff[CORDIC_STAGES] ? -x_ff[CORDIC_STAGES] : x_ff[CORDIC_STAGES];
         sin_ff <= flip_ff[CORDIC_STAGES] ? -y_ff[CORDIC_STAGES] : y_ff[CORDIC_STAGES];
      end
   end

   assign vld_o  = vld_ff[CORDIC_STAGES+1];
   assign cos_o  = cos_ff;
   assign sin_o  = sin_ff;
   assign side_o = side_ff[CORDIC_STAGES+1];

endmodule

`default_nettype wire

/* design/e2g_mul.sv */
// Two-stage signed multiply by a Q30 factor, truncated toward zero.
// Depends on e2g_pkg; the wide operand is split into two partial products.
`default_nettype none

module e2g_mul
   import e2g_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 vld_i,
   input  logic signed [VW-1:0] a_i,
   input  logic signed [RW-1:0] c_i,
   input  side_type             side_i,
   output logic                 vld_o,
   output logic signed [VW-1:0] prod_o,
   output side_type             side_o
);

   logic [VW-1:0]        ua;
   logic [RW-1:0]        uc;
   logic [MUL_HW-1:0]    ph_ff;
   logic [MUL_LW-1:0]    pl_ff;
   logic                 neg_ff;
   logic [MUL_HW:0]      mag;
   logic signed [VW-1:0] prod_ff;
   logic                 vld1_ff;
   logic                 vld2_ff;
   side_type             side1_ff;
   side_type             side2_ff;

   assign ua = $unsigned(a_i[VW-1] ? -a_i : a_i);
   assign uc = $unsigned(c_i[RW-1] ? -c_i : c_i);

   // The high part is exact in whole units; only the low part loses its fraction.
   assign mag = {1'b0, ph_ff} + (MUL_HW+1)'(pl_ff >> FRAC);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= vld_i;
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ph_ff    <= ua[VW-1:FRAC] * uc;
         pl_ff    <= ua[FRAC-1:0] * uc;
         neg_ff   <= a_i[VW-1] ^ c_i[RW-1];
         side1_ff <= side_i;
         prod_ff  <= neg_ff ? -$signed(VW'(mag)) : $signed(VW'(mag));
         side2_ff <= side1_ff;
      end
   end

   assign vld_o  = vld2_ff;
   assign prod_o = prod_ff;
   assign side_o = side2_ff;

endmodule

`default_nettype wire

/* design/e2g_sqrt.sv */
// Pipelined floor square root of w * 2^30, one result bit per stage.
// Depends on e2g_pkg.
`default_nettype none

module e2g_sqrt
   import e2g_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              vld_i,
   input  logic [SQ_RW-1:0]  w_i,
   input  side_type          side_i,
   output logic              vld_o,
   output logic [SQ_RW-1:0]  root_o,
   output side_type          side_o
);

   logic             vld_ff  [0:SQ_STEPS];
   logic [SQ_NW-1:0] n_ff    [0:SQ_STEPS];
   logic [SQ_NW-1:0] r_ff    [0:SQ_STEPS];
   side_type         side_ff [0:SQ_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= vld_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff[0]    <= SQ_NW'(w_i) << FRAC;
         r_ff[0]    <= '0;
         side_ff[0] <= side_i;
      end
   end

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
      localparam logic [SQ_NW-1:0] BIT = SQ_NW'(1) << (SQ_TOP - 2 * k);
      logic [SQ_NW-1:0] trial;

      assign trial = r_ff[k] + BIT;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k+1] <= side_ff[k];
            if (n_ff[k] >= trial) begin
               n_ff[k+1] <= n_ff[k] - trial;
               r_ff[k+1] <= (r_ff[k] >> 1) + BIT;
            end else begin
               n_ff[k+1] <= n_ff[k];
               r_ff[k+1] <= r_ff[k] >> 1;
            end
         end
      end
   end

   assign vld_o  = vld_ff[SQ_STEPS];
   assign root_o = r_ff[SQ_STEPS][SQ_RW-1:0];
   assign side_o = side_ff[SQ_STEPS];

endmodule

`default_nettype wire

/* design/e2g_chk.sv */
// Port-level checker for ecef_to_geodetic, attached by the bind at the end.
// Depends only on the top-level ports.
`default_nettype none

module e2g_chk (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic signed [30:0] req_x_cm,
   input logic signed [30:0] req_y_cm,
   input logic signed [30:0] req_z_cm,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [31:0]        rsp_longitude_turns,
   input logic signed [31:0] rsp_latitude_angle,
   input logic signed [30:0] rsp_height_cm,
   input logic               rsp_degenerate
);

   // A held output beat stays put.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_longitude_turns)
         && $stable(rsp_latitude_angle) && $stable(rsp_height_cm))
      else $error("held output beat changed");

   // The input side stalls exactly when the output beat is held.
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow the output hold");

   // Latitude never leaves a quarter turn.
   a_lat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_latitude_angle <= 32'sd1073741824
         && rsp_latitude_angle >= -32'sd1073741824)
      else $error("latitude out of range");

   // A polar-axis point reports zero longitude and height and a pole or zero latitude.
   a_pole: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_longitude_turns == 32'd0
         && rsp_height_cm == 31'sd0
         && (rsp_latitude_angle == 32'sd1073741824
             || rsp_latitude_angle == -32'sd1073741824
             || rsp_latitude_angle == 32'sd0))
      else $error("polar-axis beat has wrong fields");

endmodule

bind ecef_to_geodetic e2g_chk u_e2g_chk (.*);

`default_nettype wire

/* sim/e2g_check.sv */
// Checker for the ECEF to geodetic block: it predicts each point's geodetic fix and compares.
// It watches both channels of the block; depends on e2g_pkg for the stage count, arctangents and constants.
`timescale 1ns / 100ps

module e2g_check
   import e2g_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [30:0] req_x_cm,
   input  logic signed [30:0] req_y_cm,
   input  logic signed [30:0] req_z_cm,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [31:0]        rsp_longitude_turns,
   input  logic signed [31:0] rsp_latitude_angle,
   input  logic signed [30:0] rsp_height_cm,
   input  logic               rsp_degenerate,
   output int                 fail_count,
   output int                 open_count
);

   typedef struct {
      logic [31:0] lon;
      logic [31:0] lat;
      logic [30:0] height;
      logic        deg;
   } geo_fix_type;

   localparam longint ONE_Q30 = 64'sd1073741824;

   geo_fix_type pending_fixes[$];

   function automatic longint mul_q30(longint a, longint c);
      logic [63:0] ua, uc, r;
      ua = (a < 0) ? -a : a;
      uc = (c < 0) ? -c : c;
      r  = (ua >> 30) * uc + (((ua & 64'h3FFF_FFFF) * uc) >> 30);
      return ((a < 0) != (c < 0)) ? -longint'(r) : longint'(r);
   endfunction

   function automatic logic [63:0] floor_root(logic [63:0] n);
      logic [63:0] res, b;
      res = 0;
      b   = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n   = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // Vectoring CORDIC: angle of (x, y) in turns * 2^32, mag gets the gained length.
   function automatic logic [31:0] vector_angle(longint x, longint y, output longint mag);
      logic [31:0] ang;
      longint      dx, dy;
      ang = 0;
      if (x < 0) begin
         x   = -x;
         y   = -y;
         ang = HALF_TURN;
      end
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x   = x + dx;
            y   = y - dy;
            ang = ang + ((i < 30) ? ATAN_TAB[i] : 32'd0);
         end else begin
            x   = x - dx;
            y   = y + dy;
            ang = ang - ((i < 30) ? ATAN_TAB[i] : 32'd0);
         end
      end
      mag = x;
      return ang;
   endfunction

   // Rotation CORDIC: Q30 cosine and sine of a signed angle in turns * 2^32.
   task automatic rotate_unit(longint ang, output longint c, output longint s);
      longint x, y, dx, dy, step;
      bit     flip;
      x    = longint'(INVK_Q30);
      y    = 0;
      flip = 0;
      if (ang > ONE_Q30) begin
         ang  = ang - 2 * ONE_Q30;
         flip = 1;
      end else if (ang < -ONE_Q30) begin
         ang  = ang + 2 * ONE_Q30;
         flip = 1;
      end
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         dx   = y >>> i;
         dy   = x >>> i;
         step = (i < 30) ? longint'(ATAN_TAB[i]) : 0;
         if (ang >= 0) begin
            x   = x - dx;
            y   = y + dy;
            ang = ang - step;
         end else begin
            x   = x + dx;
            y   = y - dy;
            ang = ang + step;
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   function automatic longint as_signed_turns(logic [31:0] u);
      return longint'($signed(u));
   endfunction

   task automatic solve_geodetic(longint x, longint y, longint z, output geo_fix_type fix);
      longint xs, ys, zs, mag, unused, p, th, ct, st, s3, c3, num, den;
      longint c, s, w, hs, h, lat;
      logic [63:0] sq;
      fix.lon = 0;
      fix.deg = 0;
      lat     = 0;
      h       = 0;
      if (x == 0 && y == 0) begin
         // On the polar axis the longitude is undefined and height is forced to zero.
         fix.deg = 1;
         lat     = (z > 0) ? ONE_Q30 : ((z < 0) ? -ONE_Q30 : 0);
      end else begin
         xs      = x * 65536;
         ys      = y * 65536;
         zs      = z * 65536;
         fix.lon = vector_angle(xs, ys, mag);
         p       = mul_q30(mag, longint'(INVK_Q30));
         th      = as_signed_turns(vector_angle(mul_q30(p, longint'(BA_Q30)), zs, unused));
         rotate_unit(th, ct, st);
         s3  = mul_q30(mul_q30(st, st), st);
         c3  = mul_q30(mul_q30(ct, ct), ct);
         num = zs + ((s3 * longint'(EPB_Q8)) >>> 22);
         den = p - ((c3 * longint'(EAC_Q8)) >>> 22);
         if (den < 0) den = 0;
         if (num == 0 && den == 0) begin
            lat = 0;
         end else begin
            lat = as_signed_turns(vector_angle(den, num, unused));
            if (lat > ONE_Q30) lat = ONE_Q30;
            if (lat < -ONE_Q30) lat = -ONE_Q30;
         end
         rotate_unit(lat, c, s);
         w = ONE_Q30 - mul_q30(longint'(E2_Q30), mul_q30(s, s));
         if (w < 0) w = 0;
         sq = floor_root(64'(w) << 30);
         hs = mul_q30(p, c) + mul_q30(zs, s) - longint'((64'(A_CM) * sq) >> 14);
         h  = (hs + (64'sd1 << 15)) >>> 16;
         if (h > longint'(H_MAX)) h = longint'(H_MAX);
         if (h < longint'(H_MIN)) h = longint'(H_MIN);
      end
      fix.lat    = lat[31:0];
      fix.height = h[30:0];
   endtask

   task automatic report(string field, longint got, longint want);
      fail_count++;
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
   endtask

   geo_fix_type fix, want;

   initial begin
      fail_count = 0;
      open_count = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            solve_geodetic(longint'(req_x_cm), longint'(req_y_cm), longint'(req_z_cm), fix);
            pending_fixes.insert(pending_fixes.size(), fix);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_fixes.size() == 0) begin
               report("unexpected beat", 1, 0);
            end else begin
               want = pending_fixes.pop_front();
               if (rsp_longitude_turns !== want.lon)
                  report("longitude_turns", rsp_longitude_turns, want.lon);
               if (rsp_latitude_angle !== want.lat)
                  report("latitude_angle", rsp_latitude_angle, $signed(want.lat));
               if (rsp_height_cm !== want.height)
                  report("height_cm", rsp_height_cm, $signed(want.height));
               if (rsp_degenerate !== want.deg)
                  report("degenerate", rsp_degenerate, want.deg);
            end
         end
         open_count = pending_fixes.size();
      end
   end

   // Anything still waiting when the run ends counts as a failure through the open count.

endmodule

/* sim/tb.sv */
// Top of the ECEF to geodetic testbench: clock, reset, point stimulus and the verdict.
// Depends on ecef_to_geodetic, e2g_check and e2g_pkg.
`timescale 1ns / 100ps

module tb
   import e2g_pkg::*;
();

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [30:0] req_x_cm;
   logic signed [30:0] req_y_cm;
   logic signed [30:0] req_z_cm;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [31:0]        rsp_longitude_turns;
   logic signed [31:0] rsp_latitude_angle;
   logic signed [30:0] rsp_height_cm;
   logic               rsp_degenerate;
   int                 fail_count;
   int                 open_count;

   // When calm is set neither side idles; hold_off asks the receiver for one long stall.
   bit calm;
   bit hold_off;

   ecef_to_geodetic dut (.*);

   e2g_check checker_i (.*);

   initial clock = 0;
   always #5 clock = ~clock;

   // Gap lengths: mostly none or short, now and then a long one.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offers one point and returns once the block has taken the beat.
   task automatic send_point(logic signed [30:0] x, logic signed [30:0] y,
                             logic signed [30:0] z);
      int gap;
      gap = idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_x_cm  <= x;
      req_y_cm  <= y;
      req_z_cm  <= z;
      do @(posedge clock); while (req_stall);
   endtask

   // Waits until every predicted fix has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (open_count != 0);
   endtask

   function automatic logic signed [30:0] any_coord();
      logic [31:0] r;
      r = $urandom();
      return r[30:0];
   endfunction

   function automatic logic signed [30:0] coord_in(int span);
      return 31'($signed($urandom_range(0, 2 * span)) - span);
   endfunction

   task automatic random_point();
      int k;
      k = $urandom_range(0, 99);
      if (k < 40)
         // Anywhere in a cube reaching a little beyond the Earth's radius on each axis.
         send_point(coord_in(700000000), coord_in(700000000), coord_in(700000000));
      else if (k < 55)
         send_point(coord_in(3000), coord_in(3000), coord_in(3000));
      else if (k < 62)
         send_point(0, 0, ($urandom_range(0, 3) == 0) ? 31'sd0 : any_coord());
      else if (k < 70)
         send_point(0, any_coord(), any_coord());
      else if (k < 76)
         send_point(any_coord(), 0, any_coord());
      else
         send_point(any_coord(), any_coord(), any_coord());
   endtask

   // Receiver: random stalls, plus one long hold-off when asked, counted here.
   initial begin
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (600) @(posedge clock);
            hold_off = 0;
         end else begin
            int n;
            n = idle_length();
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // Hard limit, far above the slowest correct run.
   initial begin
      #5ms;
      $display("** ecef_to_geodetic: FAILED **");
      $finish;
   end

   localparam logic signed [30:0] CMAX = 31'sh3FFF_FFFF;
   localparam logic signed [30:0] CMIN = 31'sh4000_0000;

   initial begin
      calm      = 1;
      hold_off  = 0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_x_cm  = '0;
      req_y_cm  = '0;
      req_z_cm  = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed points: polar axis in all three signs, the origin's neighbours where the
      // Bowring denominator goes negative, the equator, the four quadrants and range extremes.
      send_point(0, 0, 31'sd635675231);
      send_point(0, 0, -31'sd635675231);
      send_point(0, 0, 0);
      send_point(0, 0, CMAX);
      send_point(0, 0, CMIN);
      send_point(1, 0, 0);
      send_point(1, 0, 5);
      send_point(-1, 0, -5);
      send_point(31'sd637813700, 0, 0);
      send_point(0, 31'sd637813700, 0);
      send_point(-31'sd637813700, 0, 0);
      send_point(0, -31'sd637813700, 0);
      send_point(1, 0, 31'sd635675231);
      send_point(-31'sd400000000, -31'sd300000000, 31'sd350000000);
      send_point(31'sd300000000, -31'sd400000000, -31'sd350000000);
      send_point(CMAX, CMAX, CMAX);
      send_point(CMIN, CMIN, CMIN);
      send_point(CMIN, CMAX, 0);
      send_point(CMAX, CMIN, CMIN);
      send_point(CMIN, 0, CMAX);
      send_point(-1, -1, -1);
      drain();

      // The receiver holds off long enough for the pipeline to fill and stall its input.
      calm = 0;
      hold_off = 1;
      repeat (300) random_point();

      // A pause on the sending side until every fix is back.
      drain();

      repeat (350) random_point();
      calm = 1;
      repeat (150) random_point();
      calm = 0;
      repeat (200) random_point();
      drain();
      repeat (250) @(posedge clock);

      if (fail_count == 0 && open_count == 0)
         $display("** ecef_to_geodetic: PASSED **");
      else
         $display("** ecef_to_geodetic: FAILED **");
      $finish;
   end

endmodule
